// File: sv/touch_zone_hit_test_unit_defines.svh
// Assertion macros for the touch zone hit test unit.
`ifndef TOUCH_ZONE_HIT_TEST_UNIT_DEFINES_SVH
`define TOUCH_ZONE_HIT_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TZHT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("touch zone hit test check failed");

// Next-cycle implication, checked out of reset.
`define TZHT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("touch zone hit test check failed");

`endif

// File: sv/tzht_pkg.sv
// Shared types, codes and defaults of the touch zone hit test unit.
package tzht_pkg;

  localparam int LayoutDepthDef = 64;
  localparam int ActionDepthDef = 32;

  localparam logic [1:0] KIND_LAYOUT = 2'd0;
  localparam logic [1:0] KIND_ACTION = 2'd1;
  localparam logic [1:0] KIND_TOUCH  = 2'd2;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_CODE_END    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CODE_ORIGIN = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CODE_SIZE   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CODE_ROW    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CODE_COLUMN = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DEF_WIDTH   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_DEF_HEIGHT  = 3'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  index;
    logic [15:0] value;
    logic        touching;
    logic [15:0] touch_x;
    logic [15:0] touch_y;
  } item_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  action;
    logic [15:0] zone_x;
    logic [15:0] zone_y;
    logic [15:0] zone_w;
    logic [15:0] zone_h;
  } result_t;

  typedef struct packed {
    logic start;
    logic walk;
    logic wr_layout;
    logic wr_action;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic done;
  } status_t;

endpackage

// File: sv/tzht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tzht_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/tzht_ctrl.sv
// Controller: accepts items, sequences the layout walk and the result transfer.
module tzht_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic                touching_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tzht_pkg::cmd_t      cmd_o,
  input  tzht_pkg::status_t   status_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       was_touching_q, was_touching_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    was_touching_d = was_touching_q;
    out_valid_d    = out_valid_q && out_stall_i;
    cmd_o          = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.wr_layout = (kind_i == tzht_pkg::KIND_LAYOUT);
          cmd_o.wr_action = (kind_i == tzht_pkg::KIND_ACTION);
          if (kind_i == tzht_pkg::KIND_TOUCH) begin
            was_touching_d = touching_i;
            if (touching_i && !was_touching_q) begin
              cmd_o.start = 1'b1;
              state_d     = ST_WALK;
            end
          end
        end
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      was_touching_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      was_touching_q <= was_touching_d;
      out_valid_q    <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: sv/tzht_datapath.sv
// Datapath: tables, configuration registers, walk registers and result register.
module tzht_datapath #(
  parameter int LayoutDepth = tzht_pkg::LayoutDepthDef,
  parameter int ActionDepth = tzht_pkg::ActionDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tzht_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [15:0]                   cfg_wdata_i,
  input  tzht_pkg::item_t               item_i,
  input  tzht_pkg::cmd_t                cmd_i,
  output tzht_pkg::status_t             status_o,
  output tzht_pkg::result_t             result_o
);

  localparam int LaW = $clog2(LayoutDepth);
  localparam int PW  = $clog2(LayoutDepth + 1);
  localparam int AcW = $clog2(ActionDepth);
  localparam int KW  = $clog2(ActionDepth + 1);

  localparam logic [1:0] PH_WORD = 2'd0;
  localparam logic [1:0] PH_OP1  = 2'd1;
  localparam logic [1:0] PH_OP2  = 2'd2;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

  // configuration registers
  logic [7:0]  code_end_q, code_origin_q, code_size_q, code_row_q, code_column_q;
  logic [15:0] def_width_q, def_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_end_q    <= 8'd255;
      code_origin_q <= 8'd254;
      code_size_q   <= 8'd253;
      code_row_q    <= 8'd252;
      code_column_q <= 8'd251;
      def_width_q   <= 16'd16;
      def_height_q  <= 16'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tzht_pkg::CFG_CODE_END:    code_end_q    <= cfg_wdata_i[7:0];
        tzht_pkg::CFG_CODE_ORIGIN: code_origin_q <= cfg_wdata_i[7:0];
        tzht_pkg::CFG_CODE_SIZE:   code_size_q   <= cfg_wdata_i[7:0];
        tzht_pkg::CFG_CODE_ROW:    code_row_q    <= cfg_wdata_i[7:0];
        tzht_pkg::CFG_CODE_COLUMN: code_column_q <= cfg_wdata_i[7:0];
        tzht_pkg::CFG_DEF_WIDTH:   def_width_q   <= cfg_wdata_i;
        tzht_pkg::CFG_DEF_HEIGHT:  def_height_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // walk registers
  logic [PW-1:0] p_q, p_d;
  logic [1:0]    phase_q, phase_d;
  logic          is_origin_q, is_origin_d;
  logic          horiz_q, horiz_d;
  logic [KW-1:0] k_q, k_d;
  logic [15:0]   ox_q, ox_d, oy_q, oy_d, w_q, w_d, h_q, h_d;
  logic [15:0]   x1_q, x1_d, x2_q, x2_d, y1_q, y1_d, y2_q, y2_d;
  logic [15:0]   tx_q, ty_q;
  logic          hit_q, hit_d;
  tzht_pkg::result_t out_q;

  // tables
  logic           lay_we, lay_re, act_we, act_re;
  logic [LaW-1:0] lay_raddr;
  logic [15:0]    lay_rdata;
  logic [7:0]     act_rdata;

  assign lay_we = cmd_i.wr_layout && (32'(item_i.index) < LayoutDepth);
  assign act_we = cmd_i.wr_action && (32'(item_i.index) < ActionDepth);
  assign lay_re = cmd_i.start || cmd_i.walk;
  assign lay_raddr = cmd_i.start ? '0 : LaW'(p_q + PW'(1));

  tzht_ram #(.Width(16), .Depth(LayoutDepth)) u_layout (
    .clk_i   (clk_i),
    .we_i    (lay_we),
    .waddr_i (LaW'(item_i.index)),
    .wdata_i (item_i.value),
    .re_i    (lay_re),
    .raddr_i (lay_raddr),
    .rdata_o (lay_rdata)
  );

  tzht_ram #(.Width(8), .Depth(ActionDepth)) u_action (
    .clk_i   (clk_i),
    .we_i    (act_we),
    .waddr_i (AcW'(item_i.index)),
    .wdata_i (item_i.value[7:0]),
    .re_i    (act_re),
    .raddr_i (k_q[AcW-1:0]),
    .rdata_o (act_rdata)
  );

  always_comb begin
    logic [7:0]  s;
    logic [15:0] zx1, zx2, zy1, zy2;
    logic        room;
    logic        done;
    s    = lay_rdata[7:0];
    room = (32'(p_q) + 32'd3) <= LayoutDepth;
    zx1  = x1_q;
    zx2  = x2_q;
    zy1  = y1_q;
    zy2  = y2_q;
    done = 1'b0;

    p_d         = p_q;
    phase_d     = phase_q;
    is_origin_d = is_origin_q;
    horiz_d     = horiz_q;
    k_d         = k_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    w_d         = w_q;
    h_d         = h_q;
    x1_d        = x1_q;
    x2_d        = x2_q;
    y1_d        = y1_q;
    y2_d        = y2_q;
    hit_d       = hit_q;
    act_re      = 1'b0;

    if (cmd_i.start) begin
      p_d         = '0;
      phase_d     = PH_WORD;
      is_origin_d = 1'b0;
      horiz_d     = 1'b1;
      k_d         = '0;
      ox_d        = '0;
      oy_d        = '0;
      w_d         = def_width_q;
      h_d         = def_height_q;
      x1_d        = '0;
      x2_d        = '0;
      y1_d        = '0;
      y2_d        = '0;
      hit_d       = 1'b0;
    end else if (cmd_i.walk) begin
      p_d = p_q + PW'(1);
      case (phase_q)
        PH_OP1: begin
          if (is_origin_q) begin
            ox_d = lay_rdata;
          end else begin
            w_d = lay_rdata;
          end
          phase_d = PH_OP2;
        end
        PH_OP2: begin
          if (is_origin_q) begin
            oy_d = lay_rdata;
            x2_d = ox_q;
            y2_d = lay_rdata;
          end else begin
            h_d = lay_rdata;
          end
          phase_d = PH_WORD;
        end
        PH_WORD: begin
          if (s == code_end_q) begin
            done = 1'b1;
          end else if (s == code_origin_q) begin
            done        = !room;
            is_origin_d = 1'b1;
            phase_d     = PH_OP1;
          end else if (s == code_size_q) begin
            done        = !room;
            is_origin_d = 1'b0;
            phase_d     = PH_OP1;
          end else if (s == code_row_q) begin
            horiz_d = 1'b1;
            y1_d    = y2_q;
            y2_d    = sat_add(y2_q, h_q);
            x2_d    = ox_q;
          end else if (s == code_column_q) begin
            horiz_d = 1'b0;
            x1_d    = x2_q;
            x2_d    = sat_add(x2_q, w_q);
            y2_d    = oy_q;
          end else if (k_q == KW'(ActionDepth)) begin
            done = 1'b1;
          end else begin
            if (horiz_q) begin
              zx1 = x2_q;
              zx2 = sat_add(x2_q, {8'd0, s});
            end else begin
              zy1 = y2_q;
              zy2 = sat_add(y2_q, {8'd0, s});
            end
            x1_d = zx1;
            x2_d = zx2;
            y1_d = zy1;
            y2_d = zy2;
            if (tx_q >= zx1 && tx_q < zx2 && ty_q >= zy1 && ty_q < zy2) begin
              done   = 1'b1;
              hit_d  = 1'b1;
              act_re = 1'b1;
            end else begin
              k_d = k_q + KW'(1);
            end
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
      if (p_q == PW'(LayoutDepth - 1)) begin
        done = 1'b1;
      end
    end
    status_o.done = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q         <= '0;
      phase_q     <= PH_WORD;
      is_origin_q <= 1'b0;
      horiz_q     <= 1'b1;
      k_q         <= '0;
      hit_q       <= 1'b0;
    end else begin
      p_q         <= p_d;
      phase_q     <= phase_d;
      is_origin_q <= is_origin_d;
      horiz_q     <= horiz_d;
      k_q         <= k_d;
      hit_q       <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q <= ox_d;
    oy_q <= oy_d;
    w_q  <= w_d;
    h_q  <= h_d;
    x1_q <= x1_d;
    x2_q <= x2_d;
    y1_q <= y1_d;
    y2_q <= y2_d;
    if (cmd_i.start) begin
      tx_q <= item_i.touch_x;
      ty_q <= item_i.touch_y;
    end
    if (cmd_i.load_out) begin
      if (hit_q) begin
        out_q.hit    <= 1'b1;
        out_q.action <= act_rdata;
        out_q.zone_x <= x1_q;
        out_q.zone_y <= y1_q;
        out_q.zone_w <= x2_q - x1_q;
        out_q.zone_h <= y2_q - y1_q;
      end else begin
        out_q <= '0;
      end
    end
  end

  assign result_o = out_q;

endmodule

// File: sv/touch_zone_hit_test_unit.sv
// Top level of the touch zone hit test unit: controller, datapath and checks.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o  | tzht_pkg::item_t
//  out     | output    | out_valid_o / out_stall_i| tzht_pkg::result_t
//  cfg     | input     | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
// Table writes, unused kinds, releases and held presses leave the block idle.
// A new press occupies the block through its layout walk and the result
// transfer: the walk reads one layout word per cycle from the layout RAM
// read port. in_stall_o is high from a press transfer until its
// result is in the output register; a stalled output holds the walk's end.
// Reset loads control and configuration defaults; tables need no clearing.
module touch_zone_hit_test_unit #(
  parameter int LayoutDepth = tzht_pkg::LayoutDepthDef,
  parameter int ActionDepth = tzht_pkg::ActionDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tzht_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [15:0]                   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tzht_pkg::item_t               in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tzht_pkg::result_t             out_data_o
);

  tzht_pkg::cmd_t    cmd;
  tzht_pkg::status_t status;

  tzht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (in_data_i.kind),
    .touching_i  (in_data_i.touching),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  tzht_datapath #(
    .LayoutDepth (LayoutDepth),
    .ActionDepth (ActionDepth)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (out_data_o)
  );

`include "touch_zone_hit_test_unit_defines.svh"

  `TZHT_ASSERT_IMP(a_miss_is_zero, out_valid_o && !out_data_o.hit, out_data_o.action == 8'd0 && out_data_o.zone_x == 16'd0 && out_data_o.zone_y == 16'd0 && out_data_o.zone_w == 16'd0 && out_data_o.zone_h == 16'd0)
  `TZHT_ASSERT_IMP(a_hit_has_area, out_valid_o && out_data_o.hit, out_data_o.zone_w != 16'd0 && out_data_o.zone_h != 16'd0)
  `TZHT_ASSERT_IMP(a_result_after_walk, $rose(out_valid_o), $past(in_stall_o))
  `TZHT_ASSERT_NXT(a_walk_stalls_input, in_valid_i && !in_stall_o && in_data_i.kind == tzht_pkg::KIND_TOUCH && in_data_i.touching && !$past(in_data_i.touching) && $past(in_valid_i && !in_stall_o && in_data_i.kind == tzht_pkg::KIND_TOUCH), in_stall_o)

endmodule

// File: verif/tb_touch_zone_hit_test_unit.sv
// Testbench for the touch zone hit test unit: seeded layouts, random scenes, checks.
class zone_hit_mirror;
  logic [15:0] layout_mem [tzht_pkg::LayoutDepthDef];
  logic [7:0]  action_mem [tzht_pkg::ActionDepthDef];
  bit          prev_touch;
  logic [7:0]  code_end, code_origin, code_cell_size, code_new_row, code_new_column;
  logic [15:0] def_width, def_height;
  tzht_pkg::result_t pending_hits [$];
  int          mismatches;

  function new();
    prev_touch      = 1'b0;
    code_end        = 8'd255;
    code_origin     = 8'd254;
    code_cell_size  = 8'd253;
    code_new_row    = 8'd252;
    code_new_column = 8'd251;
    def_width       = 16'd16;
    def_height      = 16'd16;
    mismatches      = 0;
  endfunction

  function void set_config(logic [tzht_pkg::CfgIdxW-1:0] idx, logic [15:0] val);
    case (idx)
      tzht_pkg::CFG_CODE_END:    code_end        = val[7:0];
      tzht_pkg::CFG_CODE_ORIGIN: code_origin     = val[7:0];
      tzht_pkg::CFG_CODE_SIZE:   code_cell_size  = val[7:0];
      tzht_pkg::CFG_CODE_ROW:    code_new_row    = val[7:0];
      tzht_pkg::CFG_CODE_COLUMN: code_new_column = val[7:0];
      tzht_pkg::CFG_DEF_WIDTH:   def_width       = val;
      tzht_pkg::CFG_DEF_HEIGHT:  def_height      = val;
      default: ;
    endcase
  endfunction

  function int unsigned sat_sum(int unsigned a, int unsigned b);
    return (a + b > 65535) ? 65535 : a + b;
  endfunction

  function tzht_pkg::result_t hit_test(logic [15:0] tx, logic [15:0] ty);
    int unsigned i, k, ox, oy, w, h, x1, x2, y1, y2;
    logic [7:0]  s;
    bit          horiz;
    tzht_pkg::result_t r;
    r = '0;
    i = 0; k = 0; ox = 0; oy = 0;
    w = def_width; h = def_height;
    x1 = 0; x2 = 0; y1 = 0; y2 = 0;
    horiz = 1'b1;
    while (i < tzht_pkg::LayoutDepthDef) begin
      s = layout_mem[i][7:0];
      i++;
      if (s == code_end) begin
        return '0;
      end else if (s == code_origin) begin
        if (i + 2 > tzht_pkg::LayoutDepthDef) return '0;
        ox = layout_mem[i];
        oy = layout_mem[i+1];
        i += 2;
        x2 = ox;
        y2 = oy;
      end else if (s == code_cell_size) begin
        if (i + 2 > tzht_pkg::LayoutDepthDef) return '0;
        w = layout_mem[i];
        h = layout_mem[i+1];
        i += 2;
      end else if (s == code_new_row) begin
        horiz = 1'b1;
        y1 = y2;
        y2 = sat_sum(y1, h);
        x2 = ox;
      end else if (s == code_new_column) begin
        horiz = 1'b0;
        x1 = x2;
        x2 = sat_sum(x1, w);
        y2 = oy;
      end else begin
        if (k >= tzht_pkg::ActionDepthDef) return '0;
        if (horiz) begin
          x1 = x2;
          x2 = sat_sum(x1, s);
        end else begin
          y1 = y2;
          y2 = sat_sum(y1, s);
        end
        if (ty >= y1 && ty < y2 && tx >= x1 && tx < x2) begin
          r.hit    = 1'b1;
          r.action = action_mem[k];
          r.zone_x = 16'(x1);
          r.zone_y = 16'(y1);
          r.zone_w = 16'(x2 - x1);
          r.zone_h = 16'(y2 - y1);
          return r;
        end
        k++;
      end
    end
    return '0;
  endfunction

  function void take_item(tzht_pkg::item_t it);
    case (it.kind)
      tzht_pkg::KIND_LAYOUT: begin
        if (it.index < tzht_pkg::LayoutDepthDef) layout_mem[it.index] = it.value;
      end
      tzht_pkg::KIND_ACTION: begin
        if (it.index < tzht_pkg::ActionDepthDef) action_mem[it.index] = it.value[7:0];
      end
      tzht_pkg::KIND_TOUCH: begin
        if (!it.touching) begin
          prev_touch = 1'b0;
        end else if (!prev_touch) begin
          prev_touch = 1'b1;
          pending_hits.push_back(hit_test(it.touch_x, it.touch_y));
        end
      end
      default: ;
    endcase
  endfunction

  function void check_hit(tzht_pkg::result_t got);
    tzht_pkg::result_t want;
    if (pending_hits.size() == 0) begin
      $error("result with no press waiting: %p", got);
      mismatches++;
      return;
    end
    want = pending_hits.pop_front();
    if (got.hit !== want.hit) begin
      $error("hit expected %0d actual %0d", want.hit, got.hit);
      mismatches++;
    end
    if (got.action !== want.action) begin
      $error("action expected %0d actual %0d", want.action, got.action);
      mismatches++;
    end
    if (got.zone_x !== want.zone_x) begin
      $error("zone_x expected %0d actual %0d", want.zone_x, got.zone_x);
      mismatches++;
    end
    if (got.zone_y !== want.zone_y) begin
      $error("zone_y expected %0d actual %0d", want.zone_y, got.zone_y);
      mismatches++;
    end
    if (got.zone_w !== want.zone_w) begin
      $error("zone_w expected %0d actual %0d", want.zone_w, got.zone_w);
      mismatches++;
    end
    if (got.zone_h !== want.zone_h) begin
      $error("zone_h expected %0d actual %0d", want.zone_h, got.zone_h);
      mismatches++;
    end
  endfunction
endclass

module tb_touch_zone_hit_test_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CfgW          = tzht_pkg::CfgIdxW;
  localparam int         LayDepth      = tzht_pkg::LayoutDepthDef;
  localparam int         ActDepth      = tzht_pkg::ActionDepthDef;
  localparam logic [1:0] KindUnused    = 2'd3;
  localparam logic [7:0] ResetEnd      = 8'd255;
  localparam logic [7:0] ResetOrigin   = 8'd254;
  localparam logic [7:0] ResetSize     = 8'd253;
  localparam logic [7:0] ResetRow      = 8'd252;
  localparam logic [7:0] ResetColumn   = 8'd251;
  localparam int         DrainCycles   = LayDepth + 8;
  localparam int         ItemsPerPhase = 240;
  localparam int         NumPhases     = 5;
  localparam logic [15:0] PhaseCfg [NumPhases][7] = '{
    '{16'd255, 16'd254, 16'd253, 16'd252, 16'd251, 16'd16,   16'd16},
    '{16'd0,   16'd1,   16'd2,   16'd3,   16'd4,   16'hFFFF, 16'hFFFF},
    '{16'd200, 16'd100, 16'd50,  16'd25,  16'd12,  16'd0,    16'd0},
    '{16'd128, 16'd128, 16'd7,   16'd7,   16'd9,   16'd1,    16'hFFFF},
    '{16'd255, 16'd254, 16'd253, 16'd252, 16'd251, 16'd300,  16'd5}
  };

  logic                clk_i;
  logic                rst_n       = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [CfgW-1:0]     cfg_index   = '0;
  logic [15:0]         cfg_wdata   = '0;
  logic                in_valid    = 1'b0;
  logic                in_stall_o;
  tzht_pkg::item_t     in_data     = '0;
  logic                out_valid_o;
  logic                out_stall   = 1'b0;
  tzht_pkg::result_t   out_data_o;

  zone_hit_mirror      mirror;
  bit                  idle_on     = 1'b1;
  int                  sent_count  = 0;

  touch_zone_hit_test_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(1, 9) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && !out_stall) mirror.check_hit(out_data_o);
  end

  function automatic tzht_pkg::item_t make_item(logic [1:0] kind, logic [5:0] index,
                                                logic [15:0] value, logic touching,
                                                logic [15:0] x, logic [15:0] y);
    tzht_pkg::item_t it;
    it.kind     = kind;
    it.index    = index;
    it.value    = value;
    it.touching = touching;
    it.touch_x  = x;
    it.touch_y  = y;
    return it;
  endfunction

  function automatic tzht_pkg::item_t touch_item(logic touching, logic [15:0] x,
                                                 logic [15:0] y);
    return make_item(tzht_pkg::KIND_TOUCH, 6'($urandom), 16'($urandom), touching, x, y);
  endfunction

  function automatic tzht_pkg::item_t write_item(logic [1:0] kind, logic [5:0] index,
                                                 logic [15:0] value);
    return make_item(kind, index, value, 1'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  function automatic logic [15:0] marker(logic [7:0] code);
    return {8'($urandom), code};
  endfunction

  function automatic logic [15:0] pick_coord();
    return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
  endfunction

  function automatic logic [15:0] pick_size();
    return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 60));
  endfunction

  function automatic logic [15:0] near(int unsigned base, int unsigned span);
    int unsigned v;
    v = base + $urandom_range(0, span);
    return (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  function automatic logic [15:0] seed_word(int i);
    case (i)
      0:  return {8'h00, ResetOrigin};
      1:  return 16'd100;
      2:  return 16'd50;
      3:  return 16'h1214;
      4:  return 16'h001E;
      5:  return {8'hA5, ResetRow};
      6:  return 16'h00FA;
      7:  return {8'h00, ResetColumn};
      8:  return 16'hFF0A;
      9:  return {8'h00, ResetSize};
      10: return 16'hFFFF;
      11: return 16'hFFFF;
      12: return {8'h00, ResetRow};
      13: return 16'h00F0;
      14: return {8'h00, ResetColumn};
      15: return 16'h00C8;
      16: return {8'h00, ResetOrigin};
      17: return 16'd65500;
      18: return 16'd65530;
      19: return 16'h00C8;
      20: return {8'h00, ResetEnd};
      default: return (i <= 45) ? 16'h5A00 : {8'h33, ResetRow};
    endcase
  endfunction

  task automatic send_item(input tzht_pkg::item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mirror.take_item(it);
    if (it.kind != KindUnused) sent_count++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (mirror.pending_hits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgW-1:0] idx, input logic [15:0] val);
    logic [15:0] data;
    data = (idx < tzht_pkg::CFG_DEF_WIDTH) ? {8'($urandom), val[7:0]} : val;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    mirror.set_config(idx, data);
  endtask

  task automatic press_at(input logic [15:0] x, input logic [15:0] y);
    send_item(touch_item(1'b0, 16'($urandom), 16'($urandom)));
    send_item(touch_item(1'b1, x, y));
  endtask

  task automatic run_scene(input bit quiet);
    logic [15:0] words [$];
    int unsigned ox, oy, lim, i, w;
    bit          many;
    idle_on = !quiet && ($urandom_range(0, 3) != 0);
    ox = 0;
    oy = 0;
    if ($urandom_range(0, 3) != 0) begin
      ox = pick_coord();
      oy = pick_coord();
      words.push_back(marker(mirror.code_origin));
      words.push_back(16'(ox));
      words.push_back(16'(oy));
    end
    if ($urandom_range(0, 1) != 0) begin
      words.push_back(marker(mirror.code_cell_size));
      words.push_back(pick_size());
      words.push_back(pick_size());
    end
    many = ($urandom_range(0, 9) == 0);
    lim = many ? 60 : $urandom_range(words.size() + 1, 62);
    while (words.size() < lim) begin
      case (many ? 2 : $urandom_range(0, 4))
        0: words.push_back(marker(mirror.code_new_row));
        1: words.push_back(marker(mirror.code_new_column));
        default: begin
          if (many) w = $urandom_range(0, 3);
          else if ($urandom_range(0, 3) == 0) w = $urandom_range(0, 255);
          else w = $urandom_range(0, 60);
          words.push_back({8'($urandom), 8'(w)});
        end
      endcase
    end
    if ($urandom_range(0, 7) != 0) words.push_back(marker(mirror.code_end));
    for (i = 0; i < words.size() && i < LayDepth; i++) begin
      send_item(write_item(tzht_pkg::KIND_LAYOUT, 6'(i), words[i]));
    end
    repeat ($urandom_range(0, 8)) begin
      send_item(write_item(tzht_pkg::KIND_ACTION, 6'($urandom_range(0, 63)), 16'($urandom)));
    end
    repeat ($urandom_range(3, 10)) begin
      case ($urandom_range(0, 9))
        0: send_item(make_item(KindUnused, 6'($urandom), 16'($urandom), 1'($urandom),
                               16'($urandom), 16'($urandom)));
        1: send_item(write_item(tzht_pkg::KIND_LAYOUT, 6'($urandom), 16'($urandom)));
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0) press_at(16'($urandom), 16'($urandom));
      else press_at(near(ox, 500), near(oy, 300));
      if ($urandom_range(0, 7) == 0) send_item(touch_item(1'b1, pick_coord(), pick_coord()));
    end
  endtask

  initial begin
    int i, ph, r, target;
    mirror = new();
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Seed both tables so every later walk reads written entries only.
    for (i = 0; i < LayDepth; i++) begin
      send_item(write_item(tzht_pkg::KIND_LAYOUT, 6'(i), seed_word(i)));
    end
    for (i = 0; i < ActDepth; i++) begin
      send_item(write_item(tzht_pkg::KIND_ACTION, 6'(i), {8'($urandom), 8'(i * 7 + 3)}));
    end

    send_item(touch_item(1'b1, 16'h0000, 16'h0000));
    send_item(touch_item(1'b0, 16'hFFFF, 16'hFFFF));
    send_item(touch_item(1'b1, 16'd105, 16'd10));
    send_item(touch_item(1'b1, 16'd105, 16'd10));
    press_at(16'd65499, 16'd65532);
    press_at(16'hFFFF, 16'hFFFF);
    send_item(make_item(KindUnused, 6'h3F, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF));
    send_item(write_item(tzht_pkg::KIND_ACTION, 6'h3F, 16'hFFFF));
    send_item(write_item(tzht_pkg::KIND_ACTION, 6'd32, 16'h00AA));
    send_item(write_item(tzht_pkg::KIND_ACTION, 6'd0, 16'h00FF));
    press_at(16'd105, 16'd10);
    // Zero-width zone in place of the end: the action table runs out.
    send_item(write_item(tzht_pkg::KIND_LAYOUT, 6'd20, 16'h0000));
    press_at(16'd0, 16'd0);
    // Row marker instead: the walk runs off the table end.
    send_item(write_item(tzht_pkg::KIND_LAYOUT, 6'd20, {8'hC3, ResetRow}));
    press_at(16'd7, 16'd7);
    send_item(write_item(tzht_pkg::KIND_LAYOUT, 6'd63, {8'h00, ResetSize}));
    press_at(16'd7, 16'd7);
    send_item(write_item(tzht_pkg::KIND_LAYOUT, 6'd62, {8'hFF, ResetOrigin}));
    press_at(16'd7, 16'd7);

    for (ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      for (r = tzht_pkg::CFG_CODE_END; r <= tzht_pkg::CFG_DEF_HEIGHT; r++) begin
        write_cfg(CfgW'(r), PhaseCfg[ph][r]);
      end
      cfg_we <= 1'b0;
      target = sent_count + ItemsPerPhase;
      while (sent_count < target) run_scene(ph == NumPhases - 1);
    end

    idle_on = 1'b0;
    in_valid <= 1'b0;
    while (mirror.pending_hits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mirror.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
